@@ src/pbgs_pkg.sv @@
package pbgs_pkg;

  localparam int MAX_SITES = 1024;
  localparam int SITE_W    = $clog2(MAX_SITES);
  localparam int FRAC_BITS = 16;

  localparam logic signed [63:0] ONE     = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF    = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] Q30     = 64'sd1 <<< 30;
  localparam logic [63:0]        LN2_Q30 = 64'd744261118;
  localparam logic [63:0]        S32MAX  = 64'd2147483647;
  localparam int                 LN2_SH  = 47;
  localparam logic [63:0]        LN2_RCP = (64'd1 << (LN2_SH + 30 - FRAC_BITS)) / LN2_Q30;

  localparam logic signed [31:0] K_720  = 32'(ONE / 720);
  localparam logic signed [31:0] K_24   = 32'(ONE / 24);
  localparam logic signed [31:0] K_2    = 32'(ONE / 2);
  localparam logic signed [31:0] K_5040 = 32'(ONE / 5040);
  localparam logic signed [31:0] K_120  = 32'(ONE / 120);
  localparam logic signed [31:0] K_6    = 32'(ONE / 6);
  localparam logic signed [31:0] D_40320  = 32'sd40320;
  localparam logic signed [31:0] D_362880 = 32'sd362880;

  localparam logic [2:0] REG_IONIC  = 3'd0;
  localparam logic [2:0] REG_FIELD  = 3'd1;
  localparam logic [2:0] REG_CHARGE = 3'd2;
  localparam logic [2:0] REG_STEP   = 3'd3;
  localparam logic [2:0] REG_TOL    = 3'd4;
  localparam logic [2:0] REG_MAXIT  = 3'd5;
  localparam logic [2:0] REG_LAST   = 3'd6;

  typedef logic signed [31:0] fix_t;

  function automatic fix_t sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  // floor(2^30 / i) for the series term divisors
  function automatic fix_t rcp_q30(input logic [3:0] i);
    case (i)
      4'd1:    return 32'(Q30 / 1);
      4'd2:    return 32'(Q30 / 2);
      4'd3:    return 32'(Q30 / 3);
      4'd4:    return 32'(Q30 / 4);
      4'd5:    return 32'(Q30 / 5);
      4'd6:    return 32'(Q30 / 6);
      4'd7:    return 32'(Q30 / 7);
      4'd8:    return 32'(Q30 / 8);
      4'd9:    return 32'(Q30 / 9);
      4'd10:   return 32'(Q30 / 10);
      4'd11:   return 32'(Q30 / 11);
      4'd12:   return 32'(Q30 / 12);
      default: return 32'(Q30 / 13);
    endcase
  endfunction

endpackage

@@ src/pbgs_ram.sv @@
module pbgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/poisson_boltzmann_gradient_solver.sv @@
// Poisson-Boltzmann 1D gradient descent solver, Q16.16.
// Request channel: in_valid/in_stall with kind and site_index. A request is
// taken while the block is idle; in_stall is high while one is in work.
// kind 0 clears the potential store, then runs sweeps: per sweep a hyperbolic
// pass, a gradient pass and, unless converged, a copy-back pass, each over
// sites 0..last_site (0..1 if last_site is 0). A hyperbolic evaluation is a
// 13-term series by reciprocal multiplication and one division on the shared
// restoring divider; a gradient adds up to two more evaluations and four
// divisions. kind 1 reads one site.
// Result channel: out_valid/out_stall from an output register; a result
// waiting on a stalled receiver does not block the next request, but a
// finished request waits until the register is free.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index, cfg_data;
// write only while idle. Index 7 is ignored.
// Reset: config to defaults (last_site 1), statistics to zero, reads return
// zero until the first solve.
module poisson_boltzmann_gradient_solver (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic [9:0]                site_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        site_potential,
  output logic [30:0]               max_change,
  output logic [20:0]               sweeps_done,
  output logic                      converged,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data
);
  import pbgs_pkg::*;

  localparam logic [5:0] S_IDLE = 6'd0,  S_RD0 = 6'd1,  S_RD1 = 6'd2,  S_OUTW = 6'd3,
                         S_Z0 = 6'd4,    S_A0 = 6'd5,   S_A1 = 6'd6,   S_A2 = 6'd7,
                         S_B0 = 6'd8,    S_B1 = 6'd9,   S_B2 = 6'd10,  S_B3 = 6'd11,
                         S_G0 = 6'd12,   S_G1 = 6'd13,  S_G2 = 6'd14,  S_G3 = 6'd15,
                         S_G4 = 6'd16,   S_G5 = 6'd17,  S_G6 = 6'd18,  S_G7 = 6'd19,
                         S_G8 = 6'd20,   S_G9 = 6'd21,  S_G10 = 6'd22, S_G11 = 6'd23,
                         S_GS = 6'd24,   S_GU = 6'd25,  S_GU2 = 6'd26, S_E0 = 6'd27,
                         S_C0 = 6'd28,   S_C1 = 6'd29,  S_E1 = 6'd30,  S_H0 = 6'd31,
                         S_H1 = 6'd32,   S_H2 = 6'd33,  S_H3 = 6'd34,  S_H4 = 6'd35,
                         S_H5 = 6'd36,   S_H5B = 6'd37, S_H6 = 6'd38,  S_Q0 = 6'd39,
                         S_Q1 = 6'd40,   S_Q2 = 6'd41,  S_Q3 = 6'd42,  S_Q4 = 6'd43,
                         S_Q5 = 6'd44,   S_Q6 = 6'd45,  S_Q7 = 6'd46,  S_Q8 = 6'd47,
                         S_Q9 = 6'd48,   S_Q9B = 6'd49, S_Q10 = 6'd50, S_Q11 = 6'd51,
                         S_Q12 = 6'd52,  S_I0 = 6'd53,  S_I1 = 6'd54,  S_I2 = 6'd55,
                         S_DW = 6'd56,   S_H1B = 6'd57, S_H1C = 6'd58, S_H3A = 6'd59,
                         S_H3B = 6'd60;

  logic [5:0] state, hyp_ret, ion_ret, div_ret;

  fix_t        ionic_coef, field_coef, charge_term;
  logic [30:0] step_size, tolerance;
  logic [19:0] max_iterations;
  logic [9:0]  last_site;

  logic [SITE_W-1:0] s, nlast, rd_idx;
  logic [19:0] iter;
  logic [30:0] delta;
  logic        store_ok;
  fix_t        res_pot;
  logic [30:0] last_max;
  logic [20:0] last_sweeps;
  logic        last_conv;

  fix_t        x_in, hsh, hch;
  logic        x_neg;
  logic [15:0] k;
  logic [29:0] r;
  logic [30:0] term;
  logic [31:0] hsum;
  logic [3:0]  hi;
  logic [63:0] v;
  logic [63:0] kprod;
  logic [30:0] rfull;
  logic [29:0] tx, qe;
  logic [4:0]  qrem;

  fix_t qd, qd2, qt, qA, qB;
  logic qfwd;

  fix_t p, pv, nx, shs, chs, ctmp, xq, grad;
  logic signed [34:0] acc;

  fix_t mul_a, mul_b;
  logic signed [63:0] prod, prod_rnd;
  fix_t fmul_res;

  logic        div_start, div_busy;
  logic [63:0] div_dvd, div_dvs, div_dvs_r, div_rem, div_q;
  logic [6:0]  div_cnt;
  logic [64:0] div_sh;

  logic              pot_we, nxt_we, hyp_we;
  logic [SITE_W-1:0] pot_raddr;
  logic [31:0]       pot_wdata, pot_rd, nxt_rd, sh_rd, ch_rd;

  fix_t na, nb, d_fwd, d_bwd, fd0, fdi, nw;
  logic [31:0] x_mag, na_mag, nb_mag;
  fix_t fdiv_res;
  logic signed [32:0] chg;
  logic [32:0] chg_abs;
  logic [30:0] chg_sat;
  logic [64:0] h_c, h_s;
  fix_t h_ch, h_sh;
  logic [31:0] h_smag;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign prod_rnd = prod + HALF;
  assign fmul_res = sat32(66'(prod_rnd >>> FRAC_BITS));

  assign na     = sat32(66'(qd) - 66'(hsh));
  assign nb     = sat32(66'(hch) - 66'(ONE));
  assign na_mag = na[31] ? 32'(-na) : 32'(na);
  assign nb_mag = nb[31] ? 32'(-nb) : 32'(nb);
  assign x_mag  = x_in[31] ? 32'(-x_in) : 32'(x_in);

  assign d_fwd = sat32(66'(nx) - 66'(p));
  assign d_bwd = sat32(66'(p) - 66'(pv));
  assign fd0   = sat32(66'(p) - 66'(nx));
  assign fdi   = sat32(66'(p) + 66'(p) - 66'(pv) - 66'(nx));
  assign nw    = sat32(66'(p) - 66'(fmul_res));

  assign chg     = 33'(nw) - 33'(p);
  assign chg_abs = chg[32] ? 33'(-chg) : 33'(chg);
  assign chg_sat = (chg_abs > 33'(S32MAX)) ? 31'h7fffffff : chg_abs[30:0];

  always_comb begin
    logic signed [65:0] qv;
    qv = $signed({2'b00, div_q});
    if (state == S_Q11) begin
      fdiv_res = sat32(na[31] ? -qv : qv);
    end else begin
      fdiv_res = sat32(nb[31] ? -qv : qv);
    end
  end

  assign h_c    = ({1'b0, v} + {1'b0, div_q}) >> 1;
  assign h_s    = ({1'b0, v} - {1'b0, div_q}) >> 1;
  assign h_ch   = (h_c > 65'(S32MAX)) ? 32'sh7fffffff : h_c[31:0];
  assign h_smag = (h_s > 65'(S32MAX)) ? 32'h7fffffff : h_s[31:0];
  assign h_sh   = x_neg ? -$signed(h_smag) : $signed(h_smag);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_H2:  begin mul_a = $signed({1'b0, term}); mul_b = $signed({2'b00, r}); end
      S_H3A: begin mul_a = $signed({2'b00, tx}); mul_b = rcp_q30(hi); end
      S_Q0:  begin mul_a = qd;  mul_b = qd; end
      S_Q2:  begin mul_a = qd2; mul_b = K_720 + ((qd2 >= D_40320) ? 32'sd1 : 32'sd0); end
      S_Q4:  begin mul_a = qd2; mul_b = qt; end
      S_Q5:  begin mul_a = qd2; mul_b = K_5040 + ((qd2 >= D_362880) ? 32'sd1 : 32'sd0); end
      S_Q7:  begin mul_a = qd2; mul_b = qt; end
      S_Q9:  begin mul_a = qd;  mul_b = qt; end
      S_I0:  begin mul_a = chs; mul_b = qA; end
      S_I1:  begin mul_a = shs; mul_b = qB; end
      S_G1, S_G4, S_G7, S_G9: begin mul_a = ionic_coef; mul_b = xq; end
      S_G2:  begin mul_a = field_coef; mul_b = fd0; end
      S_G5:  begin mul_a = field_coef; mul_b = d_bwd; end
      S_G10: begin mul_a = field_coef; mul_b = fdi; end
      S_GU:  begin mul_a = $signed({1'b0, step_size}); mul_b = grad; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = 64'd1;
    case (state)
      S_H5B: begin div_start = 1'b1; div_dvd = (64'd1 << (2 * FRAC_BITS)) + (v >> 1);
                   div_dvs = v; end
      S_Q10: begin div_start = 1'b1; div_dvd = 64'(na_mag) << FRAC_BITS;
                   div_dvs = 64'(qd2); end
      S_Q11: begin div_start = 1'b1; div_dvd = 64'(nb_mag) << FRAC_BITS;
                   div_dvs = 64'(qd2); end
      default: begin div_start = 1'b0; end
    endcase
  end

  assign div_sh = {div_rem, div_q[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (div_start) begin
      div_rem   <= '0;
      div_q     <= div_dvd;
      div_dvs_r <= div_dvs;
      div_cnt   <= 7'd64;
      div_busy  <= 1'b1;
    end else if (div_busy) begin
      if (div_sh >= {1'b0, div_dvs_r}) begin
        div_rem <= 64'(div_sh - {1'b0, div_dvs_r});
        div_q   <= {div_q[62:0], 1'b1};
      end else begin
        div_rem <= div_sh[63:0];
        div_q   <= {div_q[62:0], 1'b0};
      end
      div_cnt <= div_cnt - 7'd1;
      if (div_cnt == 7'd1) begin
        div_busy <= 1'b0;
      end
    end
  end

  always_comb begin
    case (state)
      S_B1:    pot_raddr = (s == '0) ? s : s - 1'b1;
      S_B2:    pot_raddr = (s == nlast) ? s : s + 1'b1;
      S_RD0:   pot_raddr = rd_idx;
      default: pot_raddr = s;
    endcase
  end

  assign pot_we    = (state == S_Z0) || (state == S_C1);
  assign pot_wdata = (state == S_C1) ? nxt_rd : 32'd0;
  assign nxt_we    = (state == S_GU2);
  assign hyp_we    = (state == S_A2);

  pbgs_ram #(.WIDTH(32), .DEPTH(MAX_SITES)) u_pot (
    .clk(clk), .we(pot_we), .waddr(s), .wdata(pot_wdata),
    .raddr(pot_raddr), .rdata(pot_rd)
  );

  pbgs_ram #(.WIDTH(32), .DEPTH(MAX_SITES)) u_nxt (
    .clk(clk), .we(nxt_we), .waddr(s), .wdata(nw),
    .raddr(s), .rdata(nxt_rd)
  );

  pbgs_ram #(.WIDTH(32), .DEPTH(MAX_SITES)) u_sh (
    .clk(clk), .we(hyp_we), .waddr(s), .wdata(hsh),
    .raddr(s), .rdata(sh_rd)
  );

  pbgs_ram #(.WIDTH(32), .DEPTH(MAX_SITES)) u_ch (
    .clk(clk), .we(hyp_we), .waddr(s), .wdata(hch),
    .raddr(s), .rdata(ch_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ionic_coef     <= '0;
      field_coef     <= '0;
      charge_term    <= '0;
      step_size      <= '0;
      tolerance      <= '0;
      max_iterations <= '0;
      last_site      <= 10'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IONIC:  ionic_coef     <= cfg_data;
        REG_FIELD:  field_coef     <= cfg_data;
        REG_CHARGE: charge_term    <= cfg_data;
        REG_STEP:   step_size      <= cfg_data[30:0];
        REG_TOL:    tolerance      <= cfg_data[30:0];
        REG_MAXIT:  max_iterations <= cfg_data[19:0];
        REG_LAST:   last_site      <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUTW && (!out_valid || !out_stall)) begin
      out_valid      <= 1'b1;
      site_potential <= res_pot;
      max_change     <= last_max;
      sweeps_done    <= last_sweeps;
      converged      <= last_conv;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      store_ok    <= 1'b0;
      last_max    <= '0;
      last_sweeps <= '0;
      last_conv   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (kind) begin
              rd_idx <= site_index;
              state  <= S_RD0;
            end else begin
              nlast <= (last_site == '0) ? SITE_W'(1) : last_site;
              s     <= '0;
              state <= S_Z0;
            end
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          res_pot <= store_ok ? $signed(pot_rd) : 32'sd0;
          state   <= S_OUTW;
        end
        S_OUTW: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        S_Z0: begin
          if (s == '1) begin
            s        <= '0;
            iter     <= '0;
            store_ok <= 1'b1;
            state    <= S_A0;
          end else begin
            s <= s + 1'b1;
          end
        end
        S_A0: state <= S_A1;
        S_A1: begin
          x_in    <= $signed(pot_rd);
          hyp_ret <= S_A2;
          state   <= S_H0;
        end
        S_A2: begin
          if (s == nlast) begin
            s     <= '0;
            delta <= '0;
            state <= S_B0;
          end else begin
            s     <= s + 1'b1;
            state <= S_A0;
          end
        end
        S_B0: state <= S_B1;
        S_B1: begin
          p     <= $signed(pot_rd);
          shs   <= $signed(sh_rd);
          chs   <= $signed(ch_rd);
          state <= S_B2;
        end
        S_B2: begin
          pv    <= $signed(pot_rd);
          state <= S_B3;
        end
        S_B3: begin
          nx    <= $signed(pot_rd);
          state <= S_G0;
        end
        S_G0: begin
          if (s == '0) begin
            qd <= d_fwd; qfwd <= 1'b1; ion_ret <= S_G1;
          end else if (s == nlast) begin
            qd <= d_bwd; qfwd <= 1'b0; ion_ret <= S_G4;
          end else begin
            qd <= d_bwd; qfwd <= 1'b0; ion_ret <= S_G7;
          end
          state <= S_Q0;
        end
        S_G1: state <= S_G2;
        S_G2: begin
          acc   <= -35'(fmul_res);
          state <= S_G3;
        end
        S_G3: begin
          acc   <= acc + 35'(fmul_res) - 35'(charge_term);
          state <= S_GS;
        end
        S_G4: state <= S_G5;
        S_G5: begin
          acc   <= 35'(fmul_res);
          state <= S_G6;
        end
        S_G6: begin
          acc   <= acc + 35'(fmul_res) - 35'(charge_term);
          state <= S_GS;
        end
        S_G7: state <= S_G8;
        S_G8: begin
          acc     <= 35'(fmul_res);
          qd      <= d_fwd;
          qfwd    <= 1'b1;
          ion_ret <= S_G9;
          state   <= S_Q0;
        end
        S_G9: state <= S_G10;
        S_G10: begin
          acc   <= acc - 35'(fmul_res);
          state <= S_G11;
        end
        S_G11: begin
          acc   <= acc + 35'(fmul_res);
          state <= S_GS;
        end
        S_GS: begin
          grad  <= sat32(66'(acc));
          state <= S_GU;
        end
        S_GU: state <= S_GU2;
        S_GU2: begin
          if (chg_sat > delta) begin
            delta <= chg_sat;
          end
          if (s == nlast) begin
            state <= S_E0;
          end else begin
            s     <= s + 1'b1;
            state <= S_B0;
          end
        end
        S_E0: begin
          if (delta <= tolerance) begin
            last_max    <= delta;
            last_sweeps <= 21'(iter) + 21'd1;
            last_conv   <= 1'b1;
            res_pot     <= '0;
            state       <= S_OUTW;
          end else begin
            s     <= '0;
            state <= S_C0;
          end
        end
        S_C0: state <= S_C1;
        S_C1: begin
          if (s == nlast) begin
            state <= S_E1;
          end else begin
            s     <= s + 1'b1;
            state <= S_C0;
          end
        end
        S_E1: begin
          if (iter == max_iterations) begin
            last_max    <= delta;
            last_sweeps <= 21'(max_iterations) + 21'd1;
            last_conv   <= 1'b0;
            res_pot     <= '0;
            state       <= S_OUTW;
          end else begin
            iter  <= iter + 1'b1;
            s     <= '0;
            state <= S_A0;
          end
        end
        S_H0: begin
          x_neg <= x_in[31];
          kprod <= 64'(x_mag) * LN2_RCP;
          state <= S_H1;
        end
        S_H1: begin
          k     <= 16'(kprod >> LN2_SH);
          state <= S_H1B;
        end
        S_H1B: begin
          rfull <= 31'((64'(x_mag) << (30 - FRAC_BITS)) - 64'(k) * LN2_Q30);
          state <= S_H1C;
        end
        S_H1C: begin
          if (64'(rfull) >= LN2_Q30) begin
            k <= k + 16'd1;
            r <= 30'(64'(rfull) - LN2_Q30);
          end else begin
            r <= rfull[29:0];
          end
          term  <= 31'd1 << 30;
          hsum  <= 32'd1 << 30;
          hi    <= 4'd1;
          state <= S_H2;
        end
        S_H2: state <= S_H3;
        S_H3: begin
          tx    <= prod[59:30];
          state <= S_H3A;
        end
        S_H3A: state <= S_H3B;
        S_H3B: begin
          qe    <= prod[59:30];
          qrem  <= 5'(tx - 30'(prod[59:30] * hi));
          state <= S_H4;
        end
        S_H4: begin
          term <= 31'(qe) + ((qrem >= {1'b0, hi}) ? 31'd1 : 31'd0);
          hsum <= hsum + 32'(qe) + ((qrem >= {1'b0, hi}) ? 32'd1 : 32'd0);
          if (hi == 4'd13) begin
            state <= S_H5;
          end else begin
            hi    <= hi + 4'd1;
            state <= S_H2;
          end
        end
        S_H5: begin
          if (k >= 16'd32) begin
            v <= 64'd1 << 62;
          end else begin
            v <= ({32'd0, hsum} << k[4:0]) >> (30 - FRAC_BITS);
          end
          state <= S_H5B;
        end
        S_H5B: begin
          div_ret <= S_H6;
          state   <= S_DW;
        end
        S_H6: begin
          hch   <= h_ch;
          hsh   <= h_sh;
          state <= hyp_ret;
        end
        S_Q0: state <= S_Q1;
        S_Q1: begin
          qd2 <= fmul_res;
          if (qd > -32'(ONE) && qd < 32'(ONE)) begin
            state <= S_Q2;
          end else begin
            x_in    <= qd;
            hyp_ret <= S_Q10;
            state   <= S_H0;
          end
        end
        S_Q2: state <= S_Q3;
        S_Q3: begin
          qt    <= K_24 + fmul_res;
          state <= S_Q4;
        end
        S_Q4: state <= S_Q5;
        S_Q5: begin
          qB    <= K_2 + fmul_res;
          state <= S_Q6;
        end
        S_Q6: begin
          qt    <= K_120 + fmul_res;
          state <= S_Q7;
        end
        S_Q7: state <= S_Q8;
        S_Q8: begin
          qt    <= K_6 + fmul_res;
          state <= S_Q9;
        end
        S_Q9: state <= S_Q9B;
        S_Q9B: begin
          qA    <= -fmul_res;
          state <= S_I0;
        end
        S_Q10: begin
          div_ret <= S_Q11;
          state   <= S_DW;
        end
        S_Q11: begin
          qA      <= fdiv_res;
          div_ret <= S_Q12;
          state   <= S_DW;
        end
        S_Q12: begin
          qB    <= fdiv_res;
          state <= S_I0;
        end
        S_I0: state <= S_I1;
        S_I1: begin
          ctmp  <= fmul_res;
          state <= S_I2;
        end
        S_I2: begin
          xq    <= qfwd ? sat32(66'(ctmp) - 66'(fmul_res))
                        : sat32(66'(ctmp) + 66'(fmul_res));
          state <= ion_ret;
        end
        S_DW: begin
          if (!div_busy) begin
            state <= div_ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
